// File: rtl/core/wpre_pkg.sv
// Shared constants and types for the windowed percentile rate estimator.
package wpre_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int VAL_W        = 32;
  localparam int RATE_W       = 33;
  localparam int URGENT_COUNT = 3;

  localparam logic [VAL_W-1:0] DEFAULT_FLOOR = VAL_W'(1000);

  // Cell operations broadcast along the chain
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  // Query targets
  localparam logic [1:0] TGT_URGENT  = 2'd0;
  localparam logic [1:0] TGT_NORMAL  = 2'd1;
  localparam logic [1:0] TGT_ECONOMY = 2'd2;
  localparam logic [1:0] TGT_MINIMUM = 2'd3;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: rtl/core/wpre_cell.sv
// One cell of the sorted sample chain: holds one value and its valid bit.
module wpre_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  wpre_pkg::cell_ctrl_t       ctrl,
  input  logic                       lower_valid,
  input  logic [wpre_pkg::VAL_W-1:0] lower_value,
  input  logic                       upper_valid,
  input  logic [wpre_pkg::VAL_W-1:0] upper_value,
  output logic                       valid,
  output logic [wpre_pkg::VAL_W-1:0] value
);

  logic                       valid_next;
  logic [wpre_pkg::VAL_W-1:0] value_next;
  logic                       lower_le;

  assign lower_le = lower_valid && (lower_value <= ctrl.key);

  // Delete shifts the run at and above the evicted value down one place;
  // insert opens a gap above all values not greater than the key.
  always_comb begin
    valid_next = valid;
    value_next = value;
    case (ctrl.op)
      wpre_pkg::OP_DELETE: begin
        if (valid && (value >= ctrl.key)) begin
          valid_next = upper_valid;
          value_next = upper_value;
        end
      end
      wpre_pkg::OP_INSERT: begin
        if ((!valid || (value > ctrl.key)) && lower_le) begin
          valid_next = 1'b1;
          value_next = ctrl.key;
        end else if (lower_valid && (lower_value > ctrl.key)) begin
          valid_next = 1'b1;
          value_next = lower_value;
        end
      end
      default: begin
        valid_next = valid;
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
  end

endmodule

// File: rtl/core/wpre_chain.sv
// Row of sorted cells, ascending from cell 0, with a read port by rank.
module wpre_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  wpre_pkg::cell_ctrl_t       ctrl,
  input  logic [wpre_pkg::IDX_W-1:0] rd_idx,
  output logic [wpre_pkg::VAL_W-1:0] rd_value
);

  logic                       cell_valid [wpre_pkg::WINDOW_DEPTH];
  logic [wpre_pkg::VAL_W-1:0] cell_value [wpre_pkg::WINDOW_DEPTH];

  for (genvar i = 0; i < wpre_pkg::WINDOW_DEPTH; i++) begin : g_cell
    logic                       lo_valid;
    logic [wpre_pkg::VAL_W-1:0] lo_value;
    logic                       up_valid;
    logic [wpre_pkg::VAL_W-1:0] up_value;

    // Tie off the ends: below cell 0 sits a zero, above the top nothing
    if (i == 0) begin : g_bottom
      assign lo_valid = 1'b1;
      assign lo_value = '0;
    end else begin : g_lower
      assign lo_valid = cell_valid[i-1];
      assign lo_value = cell_value[i-1];
    end

    if (i == wpre_pkg::WINDOW_DEPTH - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_value = '0;
    end else begin : g_upper
      assign up_valid = cell_valid[i+1];
      assign up_value = cell_value[i+1];
    end

    wpre_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .lower_valid (lo_valid),
      .lower_value (lo_value),
      .upper_valid (up_valid),
      .upper_value (up_value),
      .valid       (cell_valid[i]),
      .value       (cell_value[i])
    );
  end

  // Pick the value at the requested rank
  assign rd_value = cell_value[rd_idx];

endmodule

// File: rtl/core/windowed_percentile_rate_estimator.sv
// Top level of the windowed percentile rate estimator.
//
// Commands are taken when start is high and busy is low. An add of a nonzero
// sample keeps the block busy through the delete state, which evicts the
// oldest sample from the sorted cell chain when full, and the insert state;
// an add of zero leaves the block idle and changes nothing. A query keeps the
// block busy through the query and output states; its rate appears with
// rate_valid high for exactly one cycle, registered from the output state;
// the receiver cannot stall it, so it must take the word in that cycle.
// Normal and economy queries read one rank of the chain, urgent ones use the
// newest samples' peak plus half, then raise to the floor. The floor register
// may be written at any time the block is idle; cfg_ready is always high.
module windowed_percentile_rate_estimator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [wpre_pkg::VAL_W-1:0]  sample_value,
  input  logic [1:0]                  target,
  output logic                        rate_valid,
  output logic [wpre_pkg::RATE_W-1:0] rate,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wpre_pkg::VAL_W-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEL  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_QRY  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [wpre_pkg::VAL_W-1:0]  rate_floor;
  logic [wpre_pkg::VAL_W-1:0]  sample_q;
  logic [1:0]                  target_q;
  logic [wpre_pkg::IDX_W-1:0]  write_position;
  logic [wpre_pkg::CNT_W-1:0]  fill_count;
  logic [wpre_pkg::VAL_W-1:0]  newest [wpre_pkg::URGENT_COUNT];
  logic [wpre_pkg::VAL_W-1:0]  window_store [wpre_pkg::WINDOW_DEPTH];
  logic [wpre_pkg::VAL_W-1:0]  oldest_q;
  logic [wpre_pkg::RATE_W-1:0] cand;
  logic [wpre_pkg::RATE_W-1:0] cand_next;

  logic                        accept;
  logic                        full;
  wpre_pkg::cell_ctrl_t        ctrl;
  logic [wpre_pkg::CNT_W-1:0]  rank;
  logic [wpre_pkg::IDX_W-1:0]  rd_idx;
  logic [wpre_pkg::VAL_W-1:0]  rd_value;
  logic [wpre_pkg::VAL_W-1:0]  urgent_max;
  logic [wpre_pkg::VAL_W-1:0]  floor_eff;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign full      = (fill_count == wpre_pkg::CNT_W'(wpre_pkg::WINDOW_DEPTH));
  assign floor_eff = (rate_floor == '0) ? wpre_pkg::DEFAULT_FLOOR : rate_floor;

  // Floor register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_floor <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rate_floor <= cfg_data;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == wpre_pkg::CMD_QUERY) begin
            state_next = S_QRY;
          end else if (sample_value != '0) begin
            state_next = S_DEL;
          end
        end
      end
      S_DEL:   state_next = S_INS;
      S_INS:   state_next = S_IDLE;
      S_QRY:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the command word
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample_value;
      target_q <= target;
    end
  end

  // Ring store of samples; always read the slot that is oldest when full
  always_ff @(posedge clk) begin
    if (state == S_DEL) begin
      window_store[write_position] <= sample_q;
    end
    oldest_q <= window_store[write_position];
  end

  // Advance position and count, shift the newest samples
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      fill_count     <= '0;
    end else if (state == S_DEL) begin
      write_position <= write_position + 1'b1;
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DEL) begin
      newest[0] <= sample_q;
      for (int i = 1; i < wpre_pkg::URGENT_COUNT; i++) begin
        newest[i] <= newest[i-1];
      end
    end
  end

  // Drive the chain: drop the oldest when full, then insert
  always_comb begin
    ctrl.op  = wpre_pkg::OP_HOLD;
    ctrl.key = sample_q;
    case (state)
      S_DEL: begin
        if (full) begin
          ctrl.op  = wpre_pkg::OP_DELETE;
          ctrl.key = oldest_q;
        end
      end
      S_INS:   ctrl.op = wpre_pkg::OP_INSERT;
      default: ctrl.op = wpre_pkg::OP_HOLD;
    endcase
  end

  wpre_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .rd_idx   (rd_idx),
    .rd_value (rd_value)
  );

  // Rank for normal and economy targets
  assign rank   = (target_q == wpre_pkg::TGT_NORMAL) ? (fill_count >> 1) : (fill_count >> 2);
  assign rd_idx = rank[wpre_pkg::IDX_W-1:0];

  // Largest of the newest samples present
  always_comb begin
    urgent_max = '0;
    for (int i = 0; i < wpre_pkg::URGENT_COUNT; i++) begin
      if ((fill_count > wpre_pkg::CNT_W'(i)) && (newest[i] > urgent_max)) begin
        urgent_max = newest[i];
      end
    end
  end

  // Candidate rate before the floor
  always_comb begin
    cand_next = '0;
    if (fill_count != '0) begin
      case (target_q)
        wpre_pkg::TGT_URGENT: begin
          cand_next = {1'b0, urgent_max} + {2'b00, urgent_max[wpre_pkg::VAL_W-1:1]};
        end
        wpre_pkg::TGT_NORMAL:  cand_next = {1'b0, rd_value};
        wpre_pkg::TGT_ECONOMY: cand_next = {1'b0, rd_value};
        default:               cand_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_QRY) begin
      cand <= cand_next;
    end
  end

  // Raise to the floor and present the result word for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_valid <= 1'b0;
    end else begin
      rate_valid <= (state == S_OUT);
    end
    if (state == S_OUT) begin
      rate <= (cand < {1'b0, floor_eff}) ? {1'b0, floor_eff} : cand;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed percentile rate estimator.

import wpre_pkg::*;

// Tracks the sample window and floor, predicts every query rate and checks results
class rate_checker;
  logic [VAL_W-1:0]  samples [WINDOW_DEPTH];
  int                next_slot;
  int                live_count;
  logic [VAL_W-1:0]  floor_reg;
  logic [RATE_W-1:0] pending_rates [$];
  int                mismatches;

  function new();
    next_slot  = 0;
    live_count = 0;
    floor_reg  = '0;
    mismatches = 0;
  endfunction

  task report(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function void set_floor(input logic [VAL_W-1:0] v);
    floor_reg = v;
  endfunction

  function int outstanding();
    return pending_rates.size();
  endfunction

  // Value at ascending rank k among the live samples, found by counting
  function logic [VAL_W-1:0] value_at_rank(input int k);
    int below;
    int upto;
    for (int i = 0; i < live_count; i++) begin
      below = 0;
      upto  = 0;
      for (int j = 0; j < live_count; j++) begin
        if (samples[j] < samples[i]) below++;
        if (samples[j] <= samples[i]) upto++;
      end
      if (below <= k && k < upto) return samples[i];
    end
    return '0;
  endfunction

  function logic [RATE_W-1:0] predict_rate(input logic [1:0] tgt);
    logic [RATE_W-1:0] fl;
    logic [RATE_W-1:0] r;
    logic [RATE_W-1:0] peak;
    int                slot;
    fl = (floor_reg == '0) ? RATE_W'(DEFAULT_FLOOR) : RATE_W'(floor_reg);
    if (live_count == 0 || tgt == TGT_MINIMUM) begin
      r = fl;
    end else if (tgt == TGT_URGENT) begin
      // Take the peak of the newest few samples, scaled by one and a half
      peak = '0;
      for (int k = 0; k < URGENT_COUNT && k < live_count; k++) begin
        slot = (next_slot - 1 - k + WINDOW_DEPTH) % WINDOW_DEPTH;
        if (RATE_W'(samples[slot]) > peak) peak = RATE_W'(samples[slot]);
      end
      r = peak + (peak >> 1);
    end else if (tgt == TGT_NORMAL) begin
      r = RATE_W'(value_at_rank(live_count / 2));
    end else begin
      r = RATE_W'(value_at_rank(live_count / 4));
    end
    if (r < fl) r = fl;
    return r;
  endfunction

  // Update the window on an add, queue the expected rate on a query
  function void note_command(input logic c, input logic [VAL_W-1:0] v,
                             input logic [1:0] tgt);
    if (c == CMD_ADD) begin
      if (v != '0) begin
        samples[next_slot] = v;
        next_slot = (next_slot + 1) % WINDOW_DEPTH;
        if (live_count < WINDOW_DEPTH) live_count++;
      end
    end else begin
      pending_rates.push_back(predict_rate(tgt));
    end
  endfunction

  task check_rate(input logic [RATE_W-1:0] got);
    logic [RATE_W-1:0] want;
    if (pending_rates.size() == 0) begin
      report($sformatf("rate %0d arrived with no query waiting", got));
    end else begin
      want = pending_rates.pop_front();
      if (got !== want) report($sformatf("rate got %0d, want %0d", got, want));
    end
  endtask
endclass

module testbench;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              cmd;
  logic [VAL_W-1:0]  sample_value;
  logic [1:0]        target;
  logic              rate_valid;
  logic [RATE_W-1:0] rate;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [VAL_W-1:0]  cfg_data;

  rate_checker rc;
  int          sender_idle_pct;
  int          cycle_count = 0;

  windowed_percentile_rate_estimator uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .sample_value (sample_value),
    .target       (target),
    .rate_valid   (rate_valid),
    .rate         (rate),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** windowed_percentile_rate_estimator: FAILED **");
      $finish;
    end
  end

  // Note each accepted command word, then check any rate on the result port
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) rc.note_command(cmd, sample_value, target);
      if (rate_valid) rc.check_rate(rate);
    end
  end

  // Present one command word, with random idle cycles ahead of it
  task automatic send_word(input logic c, input logic [VAL_W-1:0] v, input logic [1:0] tgt);
    while ($urandom_range(99) < sender_idle_pct) begin
      start        <= 1'b0;
      sample_value <= $urandom;
      @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= c;
    sample_value <= v;
    target       <= tgt;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every rate is back and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (rc.outstanding() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_floor(input logic [VAL_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rc.set_floor(v);
  endtask

  // Mostly adds of varied magnitude and queries, with some zero samples
  task automatic random_word();
    int               pick;
    logic [VAL_W-1:0] v;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: v = $urandom_range(2000, 1);
      1: v = $urandom_range(32'h0010_0000, 1);
      2: v = $urandom;
      default: v = 32'hFFFF_FFFF - $urandom_range(255);
    endcase
    if (pick < 55) begin
      send_word(CMD_ADD, v, 2'($urandom_range(3)));
    end else if (pick < 60) begin
      send_word(CMD_ADD, '0, 2'($urandom_range(3)));
    end else begin
      send_word(CMD_QUERY, $urandom, 2'($urandom_range(3)));
    end
  endtask

  task automatic run_phase(input logic [VAL_W-1:0] fl, input int idle_pct, input int words,
                           input int drain_every);
    write_floor(fl);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < words; n++) begin
      random_word();
      if (drain_every > 0 && n % drain_every == drain_every - 1) settle();
    end
  endtask

  initial begin
    rc = new();
    sender_idle_pct = 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    cmd          <= CMD_ADD;
    sample_value <= '0;
    target       <= TGT_URGENT;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty window, zero sample, extremes, short urgent history
    send_word(CMD_QUERY, 32'hFFFF_FFFF, TGT_URGENT);
    send_word(CMD_QUERY, '0, TGT_NORMAL);
    send_word(CMD_QUERY, $urandom, TGT_ECONOMY);
    send_word(CMD_QUERY, $urandom, TGT_MINIMUM);
    send_word(CMD_ADD, '0, TGT_MINIMUM);
    send_word(CMD_QUERY, $urandom, TGT_NORMAL);
    send_word(CMD_ADD, 32'd1, TGT_URGENT);
    send_word(CMD_QUERY, $urandom, TGT_URGENT);
    send_word(CMD_ADD, 32'hFFFF_FFFF, TGT_ECONOMY);
    send_word(CMD_QUERY, $urandom, TGT_URGENT);
    send_word(CMD_QUERY, $urandom, TGT_NORMAL);
    send_word(CMD_QUERY, $urandom, TGT_ECONOMY);
    send_word(CMD_QUERY, $urandom, TGT_MINIMUM);
    send_word(CMD_ADD, 32'd5000, TGT_NORMAL);
    send_word(CMD_ADD, 32'd7000, TGT_NORMAL);
    send_word(CMD_QUERY, $urandom, TGT_URGENT);
    send_word(CMD_ADD, 32'd3000, TGT_URGENT);
    send_word(CMD_QUERY, $urandom, TGT_URGENT);
    send_word(CMD_QUERY, $urandom, TGT_NORMAL);
    send_word(CMD_QUERY, $urandom, TGT_ECONOMY);

    // Random phases across floor settings and sender idle rates
    run_phase(32'd1, 0, 300, 0);
    run_phase(32'hFFFF_FFFF, 84, 150, 0);
    run_phase(32'($urandom_range(32'h0010_0000, 1000)), 0, 300, 0);
    run_phase('0, 25, 300, 60);
    run_phase(32'h8000_0000, 84, 250, 0);

    settle();
    repeat (10) @(posedge clk);
    if (rc.mismatches == 0) begin
      $display("** windowed_percentile_rate_estimator: PASSED **");
    end else begin
      $display("** windowed_percentile_rate_estimator: FAILED **");
    end
    $finish;
  end
endmodule

// File: windowed_percentile_rate_estimator.f
rtl/core/wpre_pkg.sv
rtl/core/wpre_cell.sv
rtl/core/wpre_chain.sv
rtl/core/windowed_percentile_rate_estimator.sv
dv/testbench.sv
